FILE: sv/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared types and constants of the code builder: beat payloads and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package hcb_pkg;

    // key of every internal node, the '$' character
    localparam logic [7:0] INNER_KEY = 8'h24;

    typedef struct packed {
        logic [7:0]  symbol;
        logic [23:0] frequency;
        logic        last_symbol;
    } item_t;

    typedef struct packed {
        logic [5:0]  symbol_index;
        logic [5:0]  code_length;
        logic [63:0] code_bits;
        logic        last_code;
    } code_t;

    typedef struct packed {
        logic load;
        logic build_init;
        logic scan;
        logic merge;
        logic path_init;
        logic path_rd;
        logic path_wl;
        logic path_wr;
        logic out_rd;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic merges_done;
        logic path_done;
        logic out_taken;
        logic out_last;
    } status_t;

endpackage

`default_nettype wire

FILE: sv/huffman_code_builder_top.sv
// Loading: one symbol beat per cycle, no result for beats not marked last.
// Build: each merge scans every node made so far and keeps the two best live
//   ones (one node read per cycle from node memory), then codes are pushed down
//   from the root one internal node at a time, then each result waits until taken.
// Reset clears the sequencer, symbol count and live flags; node, path and
//   child memories hold no reset and are written before they are read.
// ----------------------------------------------------------------------------
// huffman_code_builder_top
// Builds prefix codes from loaded (symbol, frequency) pairs and returns one
// code beat per symbol in load order.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_builder_top #(
    parameter int MAX_SYMBOLS = 32,
    parameter int FREQ_BITS   = 24
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         item_valid,
    output logic              item_ready,
    input  hcb_pkg::item_t    item,
    output logic              code_valid,
    input  wire logic         code_ready,
    output hcb_pkg::code_t    code
);
    import hcb_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer
    hcb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_last  (item.last_symbol),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // storage and arithmetic
    hcb_datapath #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .FREQ_BITS   (FREQ_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cmd        (cmd),
        .status     (status),
        .code_valid (code_valid),
        .code_ready (code_ready),
        .code       (code)
    );

endmodule

`default_nettype wire

FILE: sv/hcb_datapath.sv
// ----------------------------------------------------------------------------
// hcb_datapath
// Node storage, two-best scan, merge, code path propagation and the
// output register of the code builder.
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_datapath #(
    parameter int MAX_SYMBOLS = 32,
    parameter int FREQ_BITS   = 24
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  hcb_pkg::item_t      item,
    input  hcb_pkg::cmd_t       cmd,
    output hcb_pkg::status_t    status,
    output logic                code_valid,
    input  wire logic           code_ready,
    output hcb_pkg::code_t      code
);
    import hcb_pkg::*;

    localparam int NODE_COUNT  = 2 * MAX_SYMBOLS - 1;
    localparam int INNER_COUNT = MAX_SYMBOLS - 1;
    localparam int NW  = $clog2(NODE_COUNT);
    localparam int SW  = $clog2(MAX_SYMBOLS + 1);
    localparam int MW  = $clog2(MAX_SYMBOLS);
    localparam int IIW = (MAX_SYMBOLS > 2) ? $clog2(INNER_COUNT) : 1;
    localparam int WB  = FREQ_BITS + $clog2(MAX_SYMBOLS);
    localparam int NDW = 8 + WB;
    localparam logic [WB-1:0] WMASK = WB'((64'd1 << FREQ_BITS) - 64'd1);

    typedef struct packed {
        logic [5:0]  len;
        logic [63:0] bits;
    } path_t;

    typedef struct packed {
        logic [NW-1:0] left;
        logic [NW-1:0] right;
    } child_t;

    // true when node a is taken before node b
    function automatic logic before_f(
        input logic [WB-1:0] wa, input logic [7:0] ka, input logic [NW-1:0] ia,
        input logic [WB-1:0] wb, input logic [7:0] kb, input logic [NW-1:0] ib
    );
        logic r;
        if (wa != wb)
            r = (wa < wb);
        else if (ka != kb)
            r = (ka > kb);
        else
            r = (ia < ib);
        return r;
    endfunction

    // memories
    logic [NDW-1:0] node_mem [NODE_COUNT];
    path_t          path_mem [NODE_COUNT];
    child_t         child_mem [INNER_COUNT];

    logic [NDW-1:0] node_rd_reg;
    path_t          path_rd_reg;
    child_t         child_rd_reg;

    // control registers
    logic [SW-1:0]         cnt_reg, cnt_next;
    logic [NW-1:0]         total_reg, total_next;
    logic [MW-1:0]         m_reg, m_next;
    logic [NW-1:0]         i_reg, i_next;
    logic [SW-1:0]         k_reg, k_next;
    logic [NODE_COUNT-1:0] alive_reg, alive_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic                  rd_alive_reg, rd_alive_next;
    logic [NW-1:0]         rd_idx_reg, rd_idx_next;
    logic                  f1_reg, f1_next, f2_reg, f2_next;
    logic                  code_valid_reg, code_valid_next;

    // payload registers
    logic [NW-1:0] b1_idx_reg, b1_idx_next, b2_idx_reg, b2_idx_next;
    logic [WB-1:0] b1_w_reg, b1_w_next, b2_w_reg, b2_w_next;
    logic [7:0]    b1_k_reg, b1_k_next, b2_k_reg, b2_k_next;
    code_t         code_reg, code_next;

    // memory ports
    logic           node_we, node_re;
    logic [NW-1:0]  node_waddr, node_raddr;
    logic [NDW-1:0] node_wdata;
    logic           path_we, path_re;
    logic [NW-1:0]  path_waddr, path_raddr;
    path_t          path_wdata;
    logic           child_we, child_re;
    logic [IIW-1:0] child_waddr, child_raddr;

    logic           scan_issue;
    logic [WB-1:0]  x_w;
    logic [7:0]     x_k;
    logic [WB-1:0]  freq_w;
    logic [NW-1:0]  parent_addr;
    logic           out_is_last;
    logic           out_empty;

    assign scan_issue  = cmd.scan && (i_reg < total_reg);
    assign x_w         = node_rd_reg[WB-1:0];
    assign x_k         = node_rd_reg[NDW-1:WB];
    assign freq_w      = WB'(item.frequency) & WMASK;
    assign parent_addr = NW'(cnt_reg) + NW'(m_reg) - NW'(1);
    assign out_is_last = ((k_reg + SW'(1)) == cnt_reg);
    assign out_empty   = (x_k == INNER_KEY);

    // memory port selection
    always_comb
    begin
        node_we    = 1'b0;
        node_waddr = total_reg;
        node_wdata = {INNER_KEY, b1_w_reg + b2_w_reg};
        if (cmd.load && (cnt_reg < SW'(MAX_SYMBOLS)))
        begin
            node_we    = 1'b1;
            node_waddr = NW'(cnt_reg);
            node_wdata = {item.symbol, freq_w};
        end
        else if (cmd.merge)
        begin
            node_we = 1'b1;
        end
        node_re    = scan_issue || cmd.out_rd;
        node_raddr = cmd.out_rd ? NW'(k_reg) : i_reg;

        child_we    = cmd.merge;
        child_waddr = m_reg[IIW-1:0];
        child_re    = cmd.path_rd;
        child_raddr = IIW'(m_reg - MW'(1));

        path_re    = cmd.path_rd || cmd.out_rd;
        path_raddr = cmd.out_rd ? NW'(k_reg) : parent_addr;
        path_we    = cmd.path_init || cmd.path_wl || cmd.path_wr;
        priority if (cmd.path_init)
        begin
            path_waddr = total_reg - NW'(1);
            path_wdata = '0;
        end
        else if (cmd.path_wl)
        begin
            path_waddr = child_rd_reg.left;
            path_wdata = {path_rd_reg.len + 6'd1, {path_rd_reg.bits[62:0], 1'b1}};
        end
        else
        begin
            path_waddr = child_rd_reg.right;
            path_wdata = {path_rd_reg.len + 6'd1, {path_rd_reg.bits[62:0], 1'b0}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
            node_mem[node_waddr] <= node_wdata;
        if (node_re)
            node_rd_reg <= node_mem[node_raddr];
        if (path_we)
            path_mem[path_waddr] <= path_wdata;
        if (path_re)
            path_rd_reg <= path_mem[path_raddr];
        if (child_we)
            child_mem[child_waddr] <= {b1_idx_reg, b2_idx_reg};
        if (child_re)
            child_rd_reg <= child_mem[child_raddr];
    end

    // counters, live flags, scan and output register
    always_comb
    begin
        cnt_next        = cnt_reg;
        total_next      = total_reg;
        m_next          = m_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        alive_next      = alive_reg;
        f1_next         = f1_reg;
        f2_next         = f2_reg;
        b1_idx_next     = b1_idx_reg;
        b1_w_next       = b1_w_reg;
        b1_k_next       = b1_k_reg;
        b2_idx_next     = b2_idx_reg;
        b2_w_next       = b2_w_reg;
        b2_k_next       = b2_k_reg;
        code_next       = code_reg;
        code_valid_next = code_valid_reg;

        rd_vld_next   = scan_issue;
        rd_alive_next = alive_reg[i_reg];
        rd_idx_next   = i_reg;

        // load one symbol, drop it once the store is full
        if (cmd.load && (cnt_reg < SW'(MAX_SYMBOLS)))
        begin
            cnt_next                      = cnt_reg + SW'(1);
            alive_next[NW'(cnt_reg)]      = 1'b1;
        end

        if (cmd.build_init)
        begin
            total_next = NW'(cnt_reg);
            m_next     = '0;
            i_next     = '0;
            f1_next    = 1'b0;
            f2_next    = 1'b0;
        end

        // advance scan address
        if (scan_issue)
            i_next = i_reg + NW'(1);

        // keep the two best live nodes seen so far
        if (rd_vld_reg && rd_alive_reg)
        begin
            if (!f1_reg || before_f(x_w, x_k, rd_idx_reg, b1_w_reg, b1_k_reg, b1_idx_reg))
            begin
                b2_idx_next = b1_idx_reg;
                b2_w_next   = b1_w_reg;
                b2_k_next   = b1_k_reg;
                f2_next     = f1_reg;
                b1_idx_next = rd_idx_reg;
                b1_w_next   = x_w;
                b1_k_next   = x_k;
                f1_next     = 1'b1;
            end
            else if (!f2_reg ||
                     before_f(x_w, x_k, rd_idx_reg, b2_w_reg, b2_k_reg, b2_idx_reg))
            begin
                b2_idx_next = rd_idx_reg;
                b2_w_next   = x_w;
                b2_k_next   = x_k;
                f2_next     = 1'b1;
            end
        end

        // merge the two best into a new node
        if (cmd.merge)
        begin
            alive_next[b1_idx_reg] = 1'b0;
            alive_next[b2_idx_reg] = 1'b0;
            alive_next[total_reg]  = 1'b1;
            total_next             = total_reg + NW'(1);
            m_next                 = m_reg + MW'(1);
            i_next                 = '0;
            f1_next                = 1'b0;
            f2_next                = 1'b0;
        end

        if (cmd.path_init)
        begin
            m_next = MW'(cnt_reg - SW'(1));
            k_next = '0;
        end

        if (cmd.path_wr)
            m_next = m_reg - MW'(1);

        // load one result beat, close the set on the last one
        if (cmd.out_load)
        begin
            code_next.symbol_index = 6'(k_reg);
            code_next.code_length  = out_empty ? 6'd0 : path_rd_reg.len;
            code_next.code_bits    = out_empty ? 64'd0 : path_rd_reg.bits;
            code_next.last_code    = out_is_last;
            code_valid_next        = 1'b1;
            k_next                 = k_reg + SW'(1);
            if (out_is_last)
            begin
                cnt_next   = '0;
                alive_next = '0;
            end
        end
        else if (code_valid_reg && code_ready)
        begin
            code_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            total_reg      <= '0;
            m_reg          <= '0;
            i_reg          <= '0;
            k_reg          <= '0;
            alive_reg      <= '0;
            rd_vld_reg     <= 1'b0;
            f1_reg         <= 1'b0;
            f2_reg         <= 1'b0;
            code_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            total_reg      <= total_next;
            m_reg          <= m_next;
            i_reg          <= i_next;
            k_reg          <= k_next;
            alive_reg      <= alive_next;
            rd_vld_reg     <= rd_vld_next;
            f1_reg         <= f1_next;
            f2_reg         <= f2_next;
            code_valid_reg <= code_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_alive_reg <= rd_alive_next;
        rd_idx_reg   <= rd_idx_next;
        b1_idx_reg   <= b1_idx_next;
        b1_w_reg     <= b1_w_next;
        b1_k_reg     <= b1_k_next;
        b2_idx_reg   <= b2_idx_next;
        b2_w_reg     <= b2_w_next;
        b2_k_reg     <= b2_k_next;
        code_reg     <= code_next;
    end

    // status back to the controller
    assign status.scan_done   = (i_reg == total_reg) && !rd_vld_reg;
    assign status.merges_done = ((SW'(m_reg) + SW'(1)) >= cnt_reg);
    assign status.path_done   = (m_reg == '0);
    assign status.out_taken   = code_valid_reg && code_ready;
    assign status.out_last    = code_reg.last_code;

    assign code_valid = code_valid_reg;
    assign code       = code_reg;

endmodule

`default_nettype wire

FILE: sv/hcb_ctrl.sv
// ----------------------------------------------------------------------------
// hcb_ctrl
// Sequencer of the code builder: load, scan and merge rounds, code path
// propagation from the root, and result delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    input  wire logic          item_last,
    output logic               item_ready,
    input  hcb_pkg::status_t   status,
    output hcb_pkg::cmd_t      cmd
);
    import hcb_pkg::*;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_BINIT = 4'd1;
    localparam logic [3:0] S_SCHK  = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_MERGE = 4'd4;
    localparam logic [3:0] S_PINIT = 4'd5;
    localparam logic [3:0] S_PCHK  = 4'd6;
    localparam logic [3:0] S_PRD   = 4'd7;
    localparam logic [3:0] S_PWL   = 4'd8;
    localparam logic [3:0] S_PWR   = 4'd9;
    localparam logic [3:0] S_ORD   = 4'd10;
    localparam logic [3:0] S_OLD   = 4'd11;
    localparam logic [3:0] S_OWAIT = 4'd12;

    logic [3:0] state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                item_ready = 1'b1;
                cmd.load   = item_valid;
                if (item_valid && item_last)
                    state_next = S_BINIT;
            end
            S_BINIT:
            begin
                cmd.build_init = 1'b1;
                state_next     = S_SCHK;
            end
            S_SCHK:
            begin
                state_next = status.merges_done ? S_PINIT : S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                    state_next = S_MERGE;
            end
            S_MERGE:
            begin
                cmd.merge  = 1'b1;
                state_next = S_SCHK;
            end
            S_PINIT:
            begin
                cmd.path_init = 1'b1;
                state_next    = S_PCHK;
            end
            S_PCHK:
            begin
                state_next = status.path_done ? S_ORD : S_PRD;
            end
            S_PRD:
            begin
                cmd.path_rd = 1'b1;
                state_next  = S_PWL;
            end
            S_PWL:
            begin
                cmd.path_wl = 1'b1;
                state_next  = S_PWR;
            end
            S_PWR:
            begin
                cmd.path_wr = 1'b1;
                state_next  = S_PCHK;
            end
            S_ORD:
            begin
                cmd.out_rd = 1'b1;
                state_next = S_OLD;
            end
            S_OLD:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_OWAIT;
            end
            S_OWAIT:
            begin
                if (status.out_taken)
                    state_next = status.out_last ? S_LOAD : S_ORD;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire
